[design/mcc_pkg.sv]
// Shared constants, opcodes and calendar helper functions for the calendar clock.
`default_nettype none
package mcc_pkg;

  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;
  localparam int MsW     = 10;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_TICK     = 2'd0;
  localparam opcode_t OP_SET_DATE = 2'd1;
  localparam opcode_t OP_SET_TIME = 2'd2;

  localparam logic [MsW-1:0]     MS_LAST     = 10'd999;
  localparam logic [SecondW-1:0] SEC_LAST    = 6'd59;
  localparam logic [MinuteW-1:0] MIN_LAST    = 6'd59;
  localparam logic [HourW-1:0]   HOUR_LAST   = 5'd23;
  localparam logic [MonthW-1:0]  MONTH_FIRST = 4'd1;
  localparam logic [MonthW-1:0]  MONTH_LAST  = 4'd12;
  localparam logic [DayW-1:0]    DAY_FIRST   = 5'd1;
  localparam logic [YearW-1:0]   YEAR_MAX    = 14'd9999;

  localparam logic [MsW-1:0]     RST_MS     = 10'd0;
  localparam logic [SecondW-1:0] RST_SECOND = 6'd0;
  localparam logic [MinuteW-1:0] RST_MINUTE = 6'd30;
  localparam logic [HourW-1:0]   RST_HOUR   = 5'd8;
  localparam logic [DayW-1:0]    RST_DAY    = 5'd1;
  localparam logic [MonthW-1:0]  RST_MONTH  = 4'd1;
  localparam logic [YearW-1:0]   RST_YEAR   = 14'd2016;

  // y / 25 as (y * 5243) >> 17, exact for every 14-bit y.
  localparam logic [12:0] DIV25_MUL = 13'd5243;
  localparam int          DIV25_SH  = 17;

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW+12:0] prod;
    logic [9:0]        q;
    logic [YearW-1:0]  q25;
    logic              div25;
    prod  = {13'b0, y} * {14'b0, DIV25_MUL};
    q     = prod[DIV25_SH +: 10];
    q25   = YearW'({q, 4'b0000}) + YearW'({q, 3'b000}) + YearW'(q);
    div25 = (q25 == y);
    // with y a multiple of 4: century iff multiple of 25, and 400 iff also multiple of 16
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DayW-1:0] days_in(input logic [YearW-1:0] y,
                                               input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[design/mcc_in_if.sv]
// Input channel of the calendar clock: valid/ready handshake with opcode and set fields.
`default_nettype none
interface mcc_in_if;
  import mcc_pkg::*;

  logic                 valid;
  logic                 ready;
  opcode_t              opcode;
  logic [YearW-1:0]     set_year;
  logic [MonthW-1:0]    set_month;
  logic [DayW-1:0]      set_day;
  logic [HourW-1:0]     set_hour;
  logic [MinuteW-1:0]   set_minute;
  logic [SecondW-1:0]   set_second;

  modport source (
    output valid, opcode, set_year, set_month, set_day, set_hour, set_minute, set_second,
    input  ready
  );

  modport sink (
    input  valid, opcode, set_year, set_month, set_day, set_hour, set_minute, set_second,
    output ready
  );
endinterface
`default_nettype wire

[design/mcc_out_if.sv]
// Result channel of the calendar clock: valid/ready handshake with the current time.
`default_nettype none
interface mcc_out_if;
  import mcc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [YearW-1:0]     now_year;
  logic [MonthW-1:0]    now_month;
  logic [DayW-1:0]      now_day;
  logic [HourW-1:0]     now_hour;
  logic [MinuteW-1:0]   now_minute;
  logic [SecondW-1:0]   now_second;
  logic [MsW-1:0]       now_millisecond;
  logic                 set_rejected;

  modport source (
    output valid, now_year, now_month, now_day, now_hour, now_minute, now_second,
           now_millisecond, set_rejected,
    input  ready
  );

  modport sink (
    input  valid, now_year, now_month, now_day, now_hour, now_minute, now_second,
           now_millisecond, set_rejected,
    output ready
  );
endinterface
`default_nettype wire

[design/millisecond_calendar_clock_top.sv]
// Millisecond calendar clock with Gregorian leap years.
//
// Channels: in_chan carries one transaction per command (tick one millisecond,
// set date, set time); out_chan returns one transaction per command holding the
// year, month, day, hour, minute, second and millisecond after that command,
// plus set_rejected when a set command carried an out-of-range value.
// The result is registered and appears on out_chan in the cycle after the command is taken.
// Throughput: one command per cycle while the receiver keeps up; the calendar update is a single pass of
// combinational logic between the state and result registers, and its longest
// path is the leap-year check (one 14x13 multiply for the century test).
// in_chan.ready stays high while the result register is empty or being drained
// in the same cycle, so a new command is taken while a result is handed over.
// When the receiver stalls, the result holds and in_chan.ready drops until the
// result is taken; no command is lost or repeated.
// Reset: synchronous, active low; the clock restarts at 2016-01-01 08:30:00.000
// and the result register is emptied.
`default_nettype none
module millisecond_calendar_clock_top
  import mcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mcc_in_if.sink     in_chan,
  mcc_out_if.source  out_chan
);

  logic [MsW-1:0]     ms_r,     ms_nxt;
  logic [SecondW-1:0] sec_r,    sec_nxt;
  logic [MinuteW-1:0] min_r,    min_nxt;
  logic [HourW-1:0]   hour_r,   hour_nxt;
  logic [DayW-1:0]    day_r,    day_nxt;
  logic [MonthW-1:0]  month_r,  month_nxt;
  logic [YearW-1:0]   year_r,   year_nxt;
  logic               rej_nxt;

  logic               out_valid_r;
  logic [MsW-1:0]     out_ms_r;
  logic [SecondW-1:0] out_sec_r;
  logic [MinuteW-1:0] out_min_r;
  logic [HourW-1:0]   out_hour_r;
  logic [DayW-1:0]    out_day_r;
  logic [MonthW-1:0]  out_month_r;
  logic [YearW-1:0]   out_year_r;
  logic               out_rej_r;

  logic               in_accept;
  logic               date_ok;
  logic               time_ok;
  logic [DayW-1:0]    cur_len;
  logic [DayW-1:0]    set_len;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  assign cur_len = days_in(year_r, month_r);
  assign set_len = days_in(in_chan.set_year, in_chan.set_month);

  assign date_ok = (in_chan.set_year <= YEAR_MAX) &&
                   (in_chan.set_month >= MONTH_FIRST) && (in_chan.set_month <= MONTH_LAST) &&
                   (in_chan.set_day >= DAY_FIRST) && (in_chan.set_day <= set_len);
  assign time_ok = (in_chan.set_hour <= HOUR_LAST) &&
                   (in_chan.set_minute <= MIN_LAST) &&
                   (in_chan.set_second <= SEC_LAST);

  always_comb begin
    ms_nxt    = ms_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    rej_nxt   = 1'b0;
    case (in_chan.opcode)
      OP_TICK: begin
        // carry through the fields, stopping at the first that does not wrap
        if (ms_r != MS_LAST) begin
          ms_nxt = ms_r + 1'b1;
        end else begin
          ms_nxt = '0;
          if (sec_r != SEC_LAST) begin
            sec_nxt = sec_r + 1'b1;
          end else begin
            sec_nxt = '0;
            if (min_r != MIN_LAST) begin
              min_nxt = min_r + 1'b1;
            end else begin
              min_nxt = '0;
              if (hour_r != HOUR_LAST) begin
                hour_nxt = hour_r + 1'b1;
              end else begin
                hour_nxt = '0;
                if (day_r < cur_len) begin
                  day_nxt = day_r + 1'b1;
                end else begin
                  day_nxt = DAY_FIRST;
                  if (month_r < MONTH_LAST) begin
                    month_nxt = month_r + 1'b1;
                  end else begin
                    month_nxt = MONTH_FIRST;
                    year_nxt  = (year_r >= YEAR_MAX) ? '0 : year_r + 1'b1;
                  end
                end
              end
            end
          end
        end
      end
      OP_SET_DATE: begin
        if (date_ok) begin
          year_nxt  = in_chan.set_year;
          month_nxt = in_chan.set_month;
          day_nxt   = in_chan.set_day;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      OP_SET_TIME: begin
        if (time_ok) begin
          hour_nxt = in_chan.set_hour;
          min_nxt  = in_chan.set_minute;
          sec_nxt  = in_chan.set_second;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r    <= RST_MS;
      sec_r   <= RST_SECOND;
      min_r   <= RST_MINUTE;
      hour_r  <= RST_HOUR;
      day_r   <= RST_DAY;
      month_r <= RST_MONTH;
      year_r  <= RST_YEAR;
    end else if (in_accept) begin
      ms_r    <= ms_nxt;
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload: load with each accepted transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_ms_r    <= ms_nxt;
      out_sec_r   <= sec_nxt;
      out_min_r   <= min_nxt;
      out_hour_r  <= hour_nxt;
      out_day_r   <= day_nxt;
      out_month_r <= month_nxt;
      out_year_r  <= year_nxt;
      out_rej_r   <= rej_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.now_year        = out_year_r;
  assign out_chan.now_month       = out_month_r;
  assign out_chan.now_day         = out_day_r;
  assign out_chan.now_hour        = out_hour_r;
  assign out_chan.now_minute      = out_min_r;
  assign out_chan.now_second      = out_sec_r;
  assign out_chan.now_millisecond = out_ms_r;
  assign out_chan.set_rejected    = out_rej_r;

endmodule
`default_nettype wire

[design/mcc_checker.sv]
// Port-level checks of the calendar clock, bound to the top level.
`default_nettype none
module mcc_checker
  import mcc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire opcode_t            in_opcode,
  input wire logic [HourW-1:0]   in_set_hour,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [MonthW-1:0]  out_now_month,
  input wire logic [DayW-1:0]    out_now_day,
  input wire logic [HourW-1:0]   out_now_hour,
  input wire logic [MsW-1:0]     out_now_millisecond,
  input wire logic               out_set_rejected
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with no pending result");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_TICK) |=> out_valid && !out_set_rejected)
    else $error("tick transaction missing or flagged as rejected");

  a_bad_hour: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_SET_TIME) && (in_set_hour > HOUR_LAST)
      |=> out_valid && out_set_rejected)
    else $error("set time with hour out of range not rejected");

  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_now_month >= MONTH_FIRST) && (out_now_month <= MONTH_LAST) &&
                  (out_now_day >= DAY_FIRST) && (out_now_hour <= HOUR_LAST) &&
                  (out_now_millisecond <= MS_LAST))
    else $error("result field out of calendar range");

endmodule

bind millisecond_calendar_clock_top mcc_checker u_mcc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .in_opcode           (in_chan.opcode),
  .in_set_hour         (in_chan.set_hour),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_now_month       (out_chan.now_month),
  .out_now_day         (out_chan.now_day),
  .out_now_hour        (out_chan.now_hour),
  .out_now_millisecond (out_chan.now_millisecond),
  .out_set_rejected    (out_chan.set_rejected)
);
`default_nettype wire

[bench/millisecond_calendar_clock_top_tb.sv]
// Self-checking testbench for the millisecond calendar clock top level.
`timescale 1ns / 1ps
module millisecond_calendar_clock_top_tb;
  import mcc_pkg::*;

  localparam opcode_t OpUnused    = 2'd3;
  localparam int      CycleLimit  = 400000;
  localparam int      QuietFrom   = 1900;
  localparam int      DrainCycles = 8;
  localparam int      MaxReports  = 10;

  typedef struct packed {
    opcode_t              opcode;
    logic [YearW-1:0]     set_year;
    logic [MonthW-1:0]    set_month;
    logic [DayW-1:0]      set_day;
    logic [HourW-1:0]     set_hour;
    logic [MinuteW-1:0]   set_minute;
    logic [SecondW-1:0]   set_second;
  } clock_cmd_t;

  typedef struct packed {
    logic [YearW-1:0]     year;
    logic [MonthW-1:0]    month;
    logic [DayW-1:0]      day;
    logic [HourW-1:0]     hour;
    logic [MinuteW-1:0]   minute;
    logic [SecondW-1:0]   second;
    logic [MsW-1:0]       millisecond;
    logic                 rejected;
  } clock_reading_t;

  // Tracks the calendar after every accepted command and checks each returned reading.
  class calendar_scoreboard;
    logic [MsW-1:0]     cur_ms;
    logic [SecondW-1:0] cur_second;
    logic [MinuteW-1:0] cur_minute;
    logic [HourW-1:0]   cur_hour;
    logic [DayW-1:0]    cur_day;
    logic [MonthW-1:0]  cur_month;
    logic [YearW-1:0]   cur_year;
    clock_reading_t     expected_q[$];
    int                 errors;

    function new();
      cur_ms     = RST_MS;
      cur_second = RST_SECOND;
      cur_minute = RST_MINUTE;
      cur_hour   = RST_HOUR;
      cur_day    = RST_DAY;
      cur_month  = RST_MONTH;
      cur_year   = RST_YEAR;
      errors     = 0;
    endfunction

    function logic [DayW-1:0] month_length(logic [YearW-1:0] y, logic [MonthW-1:0] m);
      int yi;
      bit leap;
      yi   = int'(y);
      leap = (yi % 4 == 0) && ((yi % 100 != 0) || (yi % 400 == 0));
      case (m)
        4'd2:                                       return leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
        default:                                    return 5'd0;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_command(clock_cmd_t c);
      clock_reading_t r;
      bit carry;
      r.rejected = 1'b0;
      case (c.opcode)
        OP_TICK: begin
          // ripple the carry up from milliseconds to the year
          carry  = (cur_ms == MS_LAST);
          cur_ms = carry ? '0 : cur_ms + 1'b1;
          if (carry) begin
            carry      = (cur_second == SEC_LAST);
            cur_second = carry ? '0 : cur_second + 1'b1;
          end
          if (carry) begin
            carry      = (cur_minute == MIN_LAST);
            cur_minute = carry ? '0 : cur_minute + 1'b1;
          end
          if (carry) begin
            carry    = (cur_hour == HOUR_LAST);
            cur_hour = carry ? '0 : cur_hour + 1'b1;
          end
          if (carry) begin
            carry   = (cur_day >= month_length(cur_year, cur_month));
            cur_day = carry ? DAY_FIRST : cur_day + 1'b1;
          end
          if (carry) begin
            carry     = (cur_month >= MONTH_LAST);
            cur_month = carry ? MONTH_FIRST : cur_month + 1'b1;
          end
          if (carry) cur_year = (cur_year >= YEAR_MAX) ? '0 : cur_year + 1'b1;
        end
        OP_SET_DATE: begin
          if (c.set_year <= YEAR_MAX && c.set_month >= MONTH_FIRST &&
              c.set_month <= MONTH_LAST && c.set_day >= DAY_FIRST &&
              c.set_day <= month_length(c.set_year, c.set_month)) begin
            cur_year  = c.set_year;
            cur_month = c.set_month;
            cur_day   = c.set_day;
          end else begin
            r.rejected = 1'b1;
          end
        end
        OP_SET_TIME: begin
          if (c.set_hour <= HOUR_LAST && c.set_minute <= MIN_LAST &&
              c.set_second <= SEC_LAST) begin
            cur_hour   = c.set_hour;
            cur_minute = c.set_minute;
            cur_second = c.set_second;
          end else begin
            r.rejected = 1'b1;
          end
        end
        default: ;
      endcase
      r.year        = cur_year;
      r.month       = cur_month;
      r.day         = cur_day;
      r.hour        = cur_hour;
      r.minute      = cur_minute;
      r.second      = cur_second;
      r.millisecond = cur_ms;
      expected_q.push_back(r);
    endfunction

    function void check_reading(clock_reading_t got);
      clock_reading_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected result: %0d-%0d-%0d %0d:%0d:%0d.%0d rej %0d",
                   $time, got.year, got.month, got.day, got.hour, got.minute, got.second,
                   got.millisecond, got.rejected);
        return;
      end
      want = expected_q.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.hour !== want.hour || got.minute !== want.minute ||
          got.second !== want.second || got.millisecond !== want.millisecond ||
          got.rejected !== want.rejected) begin
        errors++;
        if (errors <= MaxReports) begin
          $write("%0t: mismatch: expected %0d-%0d-%0d %0d:%0d:%0d.%0d rej %0d",
                 $time, want.year, want.month, want.day, want.hour, want.minute,
                 want.second, want.millisecond, want.rejected);
          $display(", got %0d-%0d-%0d %0d:%0d:%0d.%0d rej %0d",
                   got.year, got.month, got.day, got.hour, got.minute, got.second,
                   got.millisecond, got.rejected);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet_tail;
  int   sent_count;
  int   cycle_count;
  int   stall_left;
  calendar_scoreboard sb;

  mcc_in_if  in_chan();
  mcc_out_if out_chan();

  millisecond_calendar_clock_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stall bursts, none in the tail of the run.
  initial begin
    out_chan.ready <= 1'b1;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_chan.ready <= 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    clock_reading_t seen;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen.year        = out_chan.now_year;
      seen.month       = out_chan.now_month;
      seen.day         = out_chan.now_day;
      seen.hour        = out_chan.now_hour;
      seen.minute      = out_chan.now_minute;
      seen.second      = out_chan.now_second;
      seen.millisecond = out_chan.now_millisecond;
      seen.rejected    = out_chan.set_rejected;
      sb.check_reading(seen);
    end
  end

  function automatic clock_cmd_t make_command(opcode_t op);
    clock_cmd_t c;
    c.opcode     = op;
    c.set_year   = YearW'($urandom_range(0, 16383));
    c.set_month  = MonthW'($urandom_range(0, 15));
    c.set_day    = DayW'($urandom_range(0, 31));
    c.set_hour   = HourW'($urandom_range(0, 31));
    c.set_minute = MinuteW'($urandom_range(0, 63));
    c.set_second = SecondW'($urandom_range(0, 63));
    return c;
  endfunction

  function automatic clock_cmd_t date_command(int y, int m, int d);
    clock_cmd_t c;
    c           = make_command(OP_SET_DATE);
    c.set_year  = YearW'(y);
    c.set_month = MonthW'(m);
    c.set_day   = DayW'(d);
    return c;
  endfunction

  function automatic clock_cmd_t time_command(int h, int mi, int s);
    clock_cmd_t c;
    c            = make_command(OP_SET_TIME);
    c.set_hour   = HourW'(h);
    c.set_minute = MinuteW'(mi);
    c.set_second = SecondW'(s);
    return c;
  endfunction

  // Mix of well-formed sets, fully random sets (mostly out of range) and unused opcodes.
  function automatic clock_cmd_t random_set();
    clock_cmd_t c;
    int y;
    int m;
    case ($urandom_range(0, 9))
      0:       c = make_command(OpUnused);
      1, 2, 3: c = make_command($urandom_range(0, 1) ? OP_SET_DATE : OP_SET_TIME);
      4, 5, 6: begin
        y = $urandom_range(0, 9999);
        m = $urandom_range(1, 12);
        c = date_command(y, m,
                         $urandom_range(1, int'(sb.month_length(YearW'(y), MonthW'(m)))));
      end
      default: c = time_command($urandom_range(0, 23), $urandom_range(0, 59),
                                $urandom_range(0, 59));
    endcase
    return c;
  endfunction

  task automatic drive_command(clock_cmd_t c);
    if (sent_count >= QuietFrom) quiet_tail = 1'b1;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_chan.valid      <= 1'b0;
      in_chan.opcode     <= opcode_t'($urandom_range(0, 3));
      in_chan.set_year   <= YearW'($urandom_range(0, 16383));
      in_chan.set_hour   <= HourW'($urandom_range(0, 31));
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.opcode     <= c.opcode;
    in_chan.set_year   <= c.set_year;
    in_chan.set_month  <= c.set_month;
    in_chan.set_day    <= c.set_day;
    in_chan.set_hour   <= c.set_hour;
    in_chan.set_minute <= c.set_minute;
    in_chan.set_second <= c.set_second;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_command(c);
    sent_count++;
  endtask

  // Hold the sender until every outstanding transaction has returned.
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int epoch;
    int pick;
    int y;
    int m;
    int d;
    sb          = new();
    quiet_tail  = 1'b0;
    sent_count  = 0;
    cycle_count = 0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.opcode     <= OP_TICK;
    in_chan.set_year   <= '0;
    in_chan.set_month  <= '0;
    in_chan.set_day    <= '0;
    in_chan.set_hour   <= '0;
    in_chan.set_minute <= '0;
    in_chan.set_second <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    drive_command(make_command(OP_TICK));
    drive_command(make_command(OpUnused));
    drive_command(time_command(23, 59, 59));
    drive_command(time_command(24, 0, 0));
    drive_command(time_command(0, 60, 0));
    drive_command(time_command(0, 0, 60));
    drive_command(time_command(31, 63, 63));
    drive_command(time_command(0, 0, 0));
    drive_command(date_command(0, 1, 1));
    drive_command(date_command(9999, 12, 31));
    drive_command(date_command(10000, 1, 1));
    drive_command(date_command(16383, 15, 31));
    drive_command(date_command(2020, 0, 10));
    drive_command(date_command(2020, 13, 10));
    drive_command(date_command(2020, 5, 0));
    drive_command(date_command(2020, 4, 31));
    drive_command(date_command(2000, 2, 29));
    drive_command(date_command(1900, 2, 29));
    drive_command(date_command(2024, 2, 29));
    drive_command(date_command(2023, 2, 29));
    drive_command(date_command(0, 2, 29));
    drive_command(date_command(2023, 2, 28));
    drive_command(make_command(OP_TICK));
    drive_command(time_command(12, 34, 56));

    // Each pass ticks up to the edge of a second, parks the calendar on a
    // rollover boundary and ticks through the carry.
    epoch = 0;
    while (sent_count < QuietFrom) begin
      wait_for_drain();
      while (sb.cur_ms < 10'd996) begin
        if ($urandom_range(0, 11) == 0) drive_command(random_set());
        else drive_command(make_command(OP_TICK));
      end
      pick = (epoch == 0) ? 0 : $urandom_range(0, 7);
      case (pick)
        0:       begin y = 9999; m = 12; d = 31; end
        1:       begin y = 2000; m = 2;  d = 29; end
        2:       begin y = 2100; m = 2;  d = 28; end
        3:       begin y = 2024; m = 2;  d = 28; end
        4:       begin y = 2023; m = 2;  d = 28; end
        5:       begin y = 2016; m = 4;  d = 30; end
        6:       begin y = 1999; m = 12; d = 31; end
        default: begin
          y = $urandom_range(0, 9999);
          m = $urandom_range(1, 12);
          d = int'(sb.month_length(YearW'(y), MonthW'(m)));
        end
      endcase
      drive_command(date_command(y, m, d));
      if (epoch == 0 || $urandom_range(0, 3) != 0) drive_command(time_command(23, 59, 59));
      else drive_command(time_command($urandom_range(0, 23), 59, 59));
      repeat ($urandom_range(8, 40)) drive_command(make_command(OP_TICK));
      epoch++;
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
